[rtl/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    localparam int unsigned CP_W       = 21;
    localparam int unsigned UNIT_W     = 16;
    localparam int unsigned JOBQ_DEPTH = 4;
    localparam int unsigned JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int unsigned JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [CP_W-1:0]   CP_QMARK = 21'h00003F;
    localparam logic [CP_W-1:0]   CP_SUPP  = 21'h010000;
    localparam logic [UNIT_W-1:0] SURR_HI  = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LO  = 16'hDC00;
    localparam logic [UNIT_W-1:0] UNIT_NUL = 16'h0000;

    // One decoded request handed from the front to the back.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            has_cp;
        logic            has_term;
    } job_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic valid;
        job_t head;
    } jobq_rd_t;

endpackage

[rtl/u8u16_front.sv]
// Front end: accepts bytes, tracks sequence state and builds code point jobs.
module u8u16_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   command,
    input  logic [7:0]             byte_in,
    output logic                   job_push,
    output u8u16_pkg::job_t        job
);
    import u8u16_pkg::*;

    logic [1:0]      pending_reg, pending_next;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic [CP_W-1:0] acc_shift;

    assign acc_shift = {acc_reg[CP_W-7:0], byte_in[5:0]};

    always_comb
    begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        job.cp       = '0;
        job.has_cp   = 1'b0;
        job.has_term = 1'b0;
        if (command == CMD_END)
        begin
            // flush a partial sequence as it stands, then close the string
            job.cp       = acc_reg;
            job.has_cp   = (pending_reg != 2'd0);
            job.has_term = 1'b1;
            pending_next = 2'd0;
            acc_next     = '0;
        end
        else if (pending_reg != 2'd0)
        begin
            pending_next = pending_reg - 2'd1;
            acc_next     = acc_shift;
            if (pending_reg == 2'd1)
            begin
                job.cp     = acc_shift;
                job.has_cp = 1'b1;
                acc_next   = '0;
            end
        end
        else if (byte_in inside {[8'h00:8'h7F]})
        begin
            job.cp     = {13'd0, byte_in};
            job.has_cp = 1'b1;
        end
        else if (byte_in inside {[8'hC0:8'hDF]})
        begin
            acc_next     = {16'd0, byte_in[4:0]};
            pending_next = 2'd1;
        end
        else if (byte_in inside {[8'hE0:8'hEF]})
        begin
            acc_next     = {17'd0, byte_in[3:0]};
            pending_next = 2'd2;
        end
        else if (byte_in inside {[8'hF0:8'hF7]})
        begin
            acc_next     = {18'd0, byte_in[2:0]};
            pending_next = 2'd3;
        end
        else
        begin
            job.cp     = CP_QMARK;
            job.has_cp = 1'b1;
        end
    end

    assign job_push = accept && (job.has_cp || job.has_term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            acc_reg     <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

[rtl/u8u16_jobq.sv]
// Short job queue that decouples the byte front end from the unit back end.
module u8u16_jobq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  u8u16_pkg::job_t        wr_job,
    output logic                   full,
    input  logic                   rd_en,
    output u8u16_pkg::jobq_rd_t    rd
);
    import u8u16_pkg::*;

    job_t               mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [JOBQ_CW-1:0] count_reg, count_next;

    assign full     = (count_reg == JOBQ_CW'(JOBQ_DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + JOBQ_CW'(1);
            2'b01:   count_next = count_reg - JOBQ_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + JOBQ_AW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + JOBQ_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

[rtl/u8u16_back.sv]
// Back end: expands each job into UTF-16 units and holds them in the output register.
module u8u16_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  u8u16_pkg::jobq_rd_t      rd,
    output logic                     rd_en,
    input  logic                     pop,
    output logic                     empty,
    output logic [15:0]              code_unit,
    output logic                     is_terminator,
    output logic                     last_of_run
);
    import u8u16_pkg::*;

    logic [1:0]        phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic              term_reg, term_next;
    logic              last_reg, last_next;

    logic              big;
    logic [CP_W-1:0]   v;
    logic [1:0]        cp_units;
    logic [1:0]        total;
    logic              load;

    assign big      = (rd.head.cp[CP_W-1:16] != '0);
    assign v        = rd.head.cp - CP_SUPP;
    assign cp_units = rd.head.has_cp ? (big ? 2'd2 : 2'd1) : 2'd0;
    assign total    = cp_units + {1'b0, rd.head.has_term};
    assign load     = rd.valid && (!out_valid_reg || pop);

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !pop;
        unit_next      = unit_reg;
        term_next      = term_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (phase_reg < cp_units)
            begin
                term_next = 1'b0;
                if (phase_reg != 2'd0)
                    unit_next = SURR_LO | {6'd0, v[9:0]};
                else if (big)
                    unit_next = SURR_HI | {5'd0, v[CP_W-1:10]};
                else
                    unit_next = rd.head.cp[UNIT_W-1:0];
            end
            else
            begin
                term_next = 1'b1;
                unit_next = UNIT_NUL;
            end
            last_next = (phase_reg == total - 2'd1);
            // retire the job on its final unit, otherwise advance within it
            if (phase_reg == total - 2'd1)
            begin
                rd_en      = 1'b1;
                phase_next = 2'd0;
            end
            else
                phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        term_reg <= term_next;
        last_reg <= last_next;
    end

    assign empty         = !out_valid_reg;
    assign code_unit     = unit_reg;
    assign is_terminator = term_reg;
    assign last_of_run   = last_reg;

endmodule

[rtl/utf8_to_utf16_transcoder_top.sv]
// Top level of the UTF-8 to UTF-16 transcoder.
// Accepts one UTF-8 byte or end-of-string request per cycle and delivers UTF-16 code
// units through a registered output, one unit per cycle while the consumer pops. The
// front end decodes each byte in the cycle it is taken; completed code points go into
// a four-entry job queue. The back end turns one job into one or two units (BMP
// character, surrogate pair, flushed partial plus zero terminator), one per cycle
// while the output register is free or popped, so input is taken at one byte per cycle
// until the queue fills; full rises when jobs arrive faster than the back end and the
// consumer drain them. A job is written into the queue at the accepting edge; when the
// output register is free, its first unit is then loaded from the queue head into it.
module utf8_to_utf16_transcoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  byte_in,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] code_unit,
    output logic        is_terminator,
    output logic        last_of_run
);
    import u8u16_pkg::*;

    logic     accept;
    logic     job_push;
    job_t     job;
    logic     rd_en;
    jobq_rd_t rd;

    assign accept = push && !full;

    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .command  (command),
        .byte_in  (byte_in),
        .job_push (job_push),
        .job      (job)
    );

    u8u16_jobq u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job),
        .full   (full),
        .rd_en  (rd_en),
        .rd     (rd)
    );

    u8u16_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd            (rd),
        .rd_en         (rd_en),
        .pop           (pop),
        .empty         (empty),
        .code_unit     (code_unit),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

endmodule

[rtl/u8u16_checker.sv]
// Port-level checks for the transcoder top level, bound to it.
module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        command,
    input logic [7:0]  byte_in,
    input logic        pop,
    input logic        empty,
    input logic [15:0] code_unit,
    input logic        is_terminator,
    input logic        last_of_run
);

    // the closing zero carries a zero unit
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_terminator) |-> (code_unit == 16'h0000))
        else $error("terminator unit is not zero");

    // nothing follows the terminator within the same request
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_terminator) |-> last_of_run)
        else $error("terminator not marked last of run");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(code_unit) && $stable(is_terminator)
                              && $stable(last_of_run)))
        else $error("waiting result changed before pop");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_chk (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 40;

    typedef struct packed {
        logic [15:0] cu;
        logic        term;
        logic        last;
    } utf16_unit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        command = CMD_DATA;
    logic [7:0]  byte_in = 8'h00;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [15:0] code_unit;
    logic        is_terminator;
    logic        last_of_run;

    // decoder copy
    logic [1:0]  cont_left = 2'd0;
    logic [20:0] cp_acc = 21'd0;

    utf16_unit_t expected_units[$];

    int send_idle_pct = 36;
    int pop_stall_pct = 36;
    int failures = 0;
    int cycles = 0;
    int n_requests = 0;
    int n_units = 0;
    int n_terms = 0;
    int n_pairs = 0;

    utf8_to_utf16_transcoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .byte_in       (byte_in),
        .pop           (pop),
        .empty         (empty),
        .code_unit     (code_unit),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d units outstanding",
                     cycles, expected_units.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void queue_unit(input logic [15:0] cu, input logic term);
        utf16_unit_t e;
        e.cu   = cu;
        e.term = term;
        e.last = 1'b0;
        expected_units.insert(expected_units.size(), e);
    endfunction

    function automatic void queue_code_point(input logic [20:0] cp);
        logic [20:0] off;
        logic [20:0] hi;
        if (cp < CP_SUPP)
            queue_unit(cp[15:0], 1'b0);
        else
        begin
            off = cp - CP_SUPP;
            hi  = off >> 10;
            queue_unit(SURR_HI | hi[15:0], 1'b0);
            queue_unit(SURR_LO | {6'd0, off[9:0]}, 1'b0);
            n_pairs++;
        end
    endfunction

    // Work out the units one accepted request produces.
    function automatic void predict_units(input logic cmd, input logic [7:0] b);
        int start;
        utf16_unit_t tail;
        start = expected_units.size();
        if (cmd == CMD_END)
        begin
            // flush a partial code point before the terminator
            if (cont_left != 2'd0)
                queue_code_point(cp_acc);
            queue_unit(UNIT_NUL, 1'b1);
            cont_left = 2'd0;
            cp_acc    = 21'd0;
        end
        else if (cont_left != 2'd0)
        begin
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
            begin
                queue_code_point(cp_acc);
                cp_acc = 21'd0;
            end
        end
        else
        begin
            casez (b)
                8'b0???????:
                    queue_unit({8'd0, b}, 1'b0);
                8'b110?????:
                begin
                    cp_acc    = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end
                8'b1110????:
                begin
                    cp_acc    = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end
                8'b11110???:
                begin
                    cp_acc    = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
                default:
                    queue_unit(CP_QMARK[15:0], 1'b0);
            endcase
        end
        if (expected_units.size() > start)
        begin
            tail = expected_units[expected_units.size() - 1];
            tail.last = 1'b1;
            expected_units[expected_units.size() - 1] = tail;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                          input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%04h, got 0x%04h", name, exp_v, act_v);
        end
    endfunction

    // Result side: check each popped unit, then pick the next pop at random.
    always @(posedge clk)
    begin : result_checker
        utf16_unit_t want;
        if (rst_n && pop && !empty)
        begin
            n_units++;
            if (expected_units.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $error("unexpected unit 0x%04h with nothing outstanding", code_unit);
            end
            else
            begin
                want = expected_units.pop_front();
                compare_field("code_unit", want.cu, code_unit);
                compare_field("is_terminator", {15'd0, want.term}, {15'd0, is_terminator});
                compare_field("last_of_run", {15'd0, want.last}, {15'd0, last_of_run});
                if (want.term)
                    n_terms++;
            end
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Hold push high until the request is taken; predict at the accepting edge.
    task automatic send_request(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        command <= cmd;
        byte_in <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_units(cmd, b);
        n_requests++;
    endtask

    task automatic stop_requests();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        stop_requests();
        while (expected_units.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_single_bytes();
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'h7F);
        // invalid leads: bare continuation and 11111xxx
        send_request(CMD_DATA, 8'h80);
        send_request(CMD_DATA, 8'hFF);
        send_request(CMD_DATA, 8'hF8);
        send_request(CMD_END, 8'hA5);
    endtask

    task automatic test_multibyte();
        send_request(CMD_DATA, 8'hC2);
        send_request(CMD_DATA, 8'hA9);
        send_request(CMD_DATA, 8'hEF);
        send_request(CMD_DATA, 8'hBF);
        send_request(CMD_DATA, 8'hBF);
        // U+1F600 and the largest 21-bit value, both as surrogate pairs
        send_request(CMD_DATA, 8'hF0);
        send_request(CMD_DATA, 8'h9F);
        send_request(CMD_DATA, 8'h98);
        send_request(CMD_DATA, 8'h80);
        send_request(CMD_DATA, 8'hF7);
        send_request(CMD_DATA, 8'hBF);
        send_request(CMD_DATA, 8'hBF);
        send_request(CMD_DATA, 8'hBF);
    endtask

    task automatic test_unchecked_and_flush();
        // ASCII byte taken as a continuation
        send_request(CMD_DATA, 8'hC3);
        send_request(CMD_DATA, 8'h41);
        // partial three-byte sequence flushed by end of string
        send_request(CMD_DATA, 8'hE2);
        send_request(CMD_DATA, 8'h82);
        send_request(CMD_END, 8'h00);
    endtask

    task automatic send_sequence(input int conts, input int sent_conts, input bit random_conts);
        logic [7:0] lead;
        int k;
        case (conts)
            1:       lead = 8'hC0 | 8'($urandom_range(31));
            2:       lead = 8'hE0 | 8'($urandom_range(15));
            default: lead = 8'hF0 | 8'($urandom_range(7));
        endcase
        send_request(CMD_DATA, lead);
        for (k = 0; k < sent_conts; k++)
        begin
            if (random_conts)
                send_request(CMD_DATA, 8'($urandom_range(255)));
            else
                send_request(CMD_DATA, 8'h80 | 8'($urandom_range(63)));
        end
    endtask

    task automatic run_random_stream(input int n_req);
        int start;
        int pick;
        int conts;
        start = n_requests;
        while (n_requests - start < n_req)
        begin
            pick  = $urandom_range(99);
            conts = $urandom_range(3, 1);
            if (pick < 20)
                send_request(CMD_DATA, 8'($urandom_range(127)));
            else if (pick < 65)
                send_sequence(conts, conts, 1'b0);
            else if (pick < 70)
                send_sequence(conts, conts, 1'b1);
            else if (pick < 80)
                send_request(CMD_END, 8'($urandom_range(255)));
            else if (pick < 90)
                send_request(CMD_DATA, 8'($urandom_range(255)));
            else
            begin
                // truncated sequence, cut off by end of string or stray bytes
                send_sequence(conts, $urandom_range(conts - 1), 1'b0);
                if ($urandom_range(1) == 0)
                    send_request(CMD_END, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random_idling();
        send_idle_pct = 36;
        pop_stall_pct = 36;
        run_random_stream(300);
    endtask

    task automatic test_random_burst();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        run_random_stream(100);
    endtask

    task automatic test_random_backpressure();
        // slow consumer so the job queue fills
        send_idle_pct = 0;
        pop_stall_pct = 75;
        run_random_stream(80);
        pop_stall_pct = 36;
        send_idle_pct = 36;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_bytes();
        test_multibyte();
        test_unchecked_and_flush();
        drain_results();
        test_random_idling();
        test_random_burst();
        test_random_backpressure();
        drain_results();
        repeat (10) @(posedge clk);

        $display("Sent %0d requests, checked %0d UTF-16 units", n_requests, n_units);
        $display("Covered %0d surrogate pairs and %0d terminators", n_pairs, n_terms);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[utf8_to_utf16_transcoder_top.f]
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_jobq.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder_top.sv
rtl/u8u16_checker.sv
tb/sv/testbench.sv
